// ===== rtl/upd_pkg.sv =====
// upd_pkg: request types, character constants and hex helpers for the
// URL percent decoder. No dependencies; used by every module under rtl/.
package upd_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam int unsigned MAX_OUT   = 3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_req;

    // Up to three decoded bytes produced by one input byte.
    typedef struct packed {
        logic                     last;
        logic [1:0]               count;
        logic [MAX_OUT-1:0][7:0]  bytes;
    } t_bundle;

    function automatic logic is_hex(input logic [7:0] c);
        logic r;
        r = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
            (c >= 8'h61 && c <= 8'h66);
        return r;
    endfunction

    // Valid only for hex characters: letters carry bit 6.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] r;
        r = c[6] ? (c[3:0] + 4'd9) : c[3:0];
        return r;
    endfunction

endpackage

// ===== rtl/url_percent_decoder.sv =====
// url_percent_decoder: streaming URL percent decoder, one byte per request.
// With the back end idle, the first decoded byte of a request passes through the
// bundle queue and then the back end's bundle register before it shows on o_out.
// Throughput: one input byte per cycle until QUEUE_DEPTH bundles wait; one result
// per cycle on the output side while the consumer pops, a bundle of two or three
// results occupies the back end until its last byte is popped. Reset (synchronous,
// active low) drops pending escapes and all queued results.
module url_percent_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input request side
    input  logic              push,
    output logic              full,
    input  upd_pkg::t_in_req  i_in,
    // result side
    output logic              empty,
    input  logic              pop,
    output upd_pkg::t_out_req o_out
);

    // Front: tracks the '%' escape phase and turns each input byte into a
    // bundle of zero to three decoded bytes. Zero-byte bundles are not queued.
    logic             q_push, q_full, q_pop, q_empty;
    upd_pkg::t_bundle q_wdata, q_rdata;

    upd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_wdata)
    );

    // Bundle queue: lets the front keep taking bytes while the back end
    // serializes a multi-byte bundle or the consumer stalls.
    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    // Back: holds the current bundle in registers and presents one byte at a
    // time; the final byte of a string's last bundle carries out_last.
    upd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_rdata),
        .o_q_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .o_out     (o_out)
    );

endmodule

// ===== rtl/upd_front.sv =====
// upd_front: escape tracking and classification of each input byte into a
// bundle of decoded bytes. Depends on upd_pkg.
module upd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  upd_pkg::t_in_req  i_in,
    input  logic              i_q_full,
    output logic              o_q_push,
    output upd_pkg::t_bundle  o_q_data
);

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_PCT  = 3'b010,
        PH_DIG  = 3'b100
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_held, n_held;
    logic        accept;
    logic [1:0]  cnt;
    logic        fresh;
    logic [7:0]  b;
    logic        b_hex;
    upd_pkg::t_bundle bnd;

    assign full   = i_q_full;
    assign accept = push && !i_q_full;
    assign b      = i_in.in_byte;
    assign b_hex  = upd_pkg::is_hex(b);

    always_comb begin
        n_phase   = r_phase;
        n_held    = r_held;
        cnt       = 2'd0;
        fresh     = 1'b1;
        bnd.bytes = '0;
        unique case (r_phase)
            PH_PCT: begin
                if (b_hex) begin
                    n_held  = b;
                    n_phase = PH_DIG;
                    fresh   = 1'b0;
                    if (i_in.in_last) begin
                        bnd.bytes[0] = upd_pkg::CH_PERCENT;
                        bnd.bytes[1] = b;
                        cnt = 2'd2;
                    end
                end else begin
                    bnd.bytes[0] = upd_pkg::CH_PERCENT;
                    cnt     = 2'd1;
                    n_phase = PH_IDLE;
                end
            end
            PH_DIG: begin
                n_phase = PH_IDLE;
                if (b_hex) begin
                    bnd.bytes[0] = {upd_pkg::hex_value(r_held), upd_pkg::hex_value(b)};
                    cnt   = 2'd1;
                    fresh = 1'b0;
                end else begin
                    bnd.bytes[0] = upd_pkg::CH_PERCENT;
                    bnd.bytes[1] = r_held;
                    cnt = 2'd2;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        if (fresh) begin
            if (b == upd_pkg::CH_PERCENT && !i_in.in_last) begin
                n_phase = PH_PCT;
            end else begin
                bnd.bytes[cnt] = (b == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE : b;
                cnt = cnt + 2'd1;
            end
        end

        if (i_in.in_last) begin
            n_phase = PH_IDLE;
            n_held  = '0;
        end
        bnd.count = cnt;
        bnd.last  = i_in.in_last;
    end

    assign o_q_push = accept && (cnt != 2'd0);
    assign o_q_data = bnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

endmodule

// ===== rtl/upd_queue.sv =====
// upd_queue: small register queue of bundles between front and back.
// Depends on upd_pkg.
module upd_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  upd_pkg::t_bundle  i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output upd_pkg::t_bundle  o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    upd_pkg::t_bundle r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/upd_back.sv =====
// upd_back: takes bundles from the queue and delivers their bytes one per
// pop on the result side. Depends on upd_pkg.
module upd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  upd_pkg::t_bundle  i_q_data,
    output logic              o_q_pop,
    output logic              empty,
    input  logic              pop,
    output upd_pkg::t_out_req o_out
);

    upd_pkg::t_bundle r_cur;
    logic             r_busy;
    logic [1:0]       r_idx;
    logic             at_end, take, load;

    assign at_end  = (r_idx == r_cur.count - 2'd1);
    assign take    = pop && r_busy;
    assign load    = (!r_busy || (take && at_end)) && !i_q_empty;
    assign o_q_pop = load;
    assign empty   = !r_busy;

    always_comb begin
        case (r_idx)
            2'd0:    o_out.out_byte = r_cur.bytes[0];
            2'd1:    o_out.out_byte = r_cur.bytes[1];
            2'd2:    o_out.out_byte = r_cur.bytes[2];
            default: o_out.out_byte = r_cur.bytes[0];
        endcase
        o_out.out_last = r_cur.last && at_end;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur <= i_q_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (take && at_end) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (take) begin
            r_idx  <= r_idx + 2'd1;
        end
    end

    a_busy_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cur.count != 2'd0))
        else $error("busy with an empty bundle");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx < r_cur.count))
        else $error("byte index past bundle count");

    a_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && at_end && !i_q_empty) |=> (r_busy && r_idx == 2'd0))
        else $error("waiting bundle not loaded after last byte");

endmodule
